/* src/mlp_relu_inference_defines.svh */
// ----------------------------------------------------------------------------
// mlp_relu_inference_defines.svh
// Assertion macros shared by the checker of the MLP inference block.
// ----------------------------------------------------------------------------
`ifndef MLP_RELU_INFERENCE_DEFINES_SVH
`define MLP_RELU_INFERENCE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define MLP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define MLP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/mlp_pkg.sv */
// ----------------------------------------------------------------------------
// mlp_pkg
// Sizes, codes and types shared by the MLP inference block.
// ----------------------------------------------------------------------------
package mlp_pkg;

   // network and number format
   localparam int MAX_LAYERS   = 4;
   localparam int MAX_WIDTH    = 16;
   localparam int DATA_BITS    = 16;
   localparam int FRAC_DEFAULT = 8;

   localparam int LAYER_BITS = $clog2(MAX_LAYERS);
   localparam int IDX_BITS   = $clog2(MAX_WIDTH);
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int LCNT_BITS  = 3;
   localparam int OP_BITS    = 2;
   localparam int OUT_BITS   = DATA_BITS - 1;
   localparam int PROD_BITS  = 2 * DATA_BITS;
   // 16 products plus the scaled bias never leave this range
   localparam int ACC_BITS   = PROD_BITS + IDX_BITS + 2;

   // storage
   localparam int WEIGHT_DEPTH = MAX_LAYERS * MAX_WIDTH * MAX_WIDTH;
   localparam int BIAS_DEPTH   = MAX_LAYERS * MAX_WIDTH;
   localparam int ACT_DEPTH    = 2 * MAX_WIDTH;

   // ports
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 24;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // item kinds on req_tuser
   typedef enum logic [OP_BITS-1:0] {
      OP_WEIGHT = 2'd0,
      OP_BIAS   = 2'd1,
      OP_INPUT  = 2'd2
   } op_type;

   // register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_LAYER_COUNT = 3'd0,
      REG_INPUT_WIDTH = 3'd1,
      REG_WIDTH_ONE   = 3'd2,
      REG_WIDTH_TWO   = 3'd3,
      REG_WIDTH_THREE = 3'd4,
      REG_WIDTH_FOUR  = 3'd5
   } reg_type;

   // sequencer to MAC unit
   typedef struct packed {
      logic load_bias;  // bias read data valid, start a neuron
      logic issue;      // weight and activation reads issued this cycle
   } mac_ctl_type;

endpackage

/* src/mlp_ram.sv */
// ----------------------------------------------------------------------------
// mlp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mlp_mac.sv */
// ----------------------------------------------------------------------------
// mlp_mac
// Shared multiply-accumulate unit: one product per cycle into a wide
// accumulator, then truncation, saturation and ReLU of the neuron sum.
// ----------------------------------------------------------------------------
module mlp_mac #(
   parameter int FRAC_BITS = mlp_pkg::FRAC_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mlp_pkg::mac_ctl_type          ctl,
   input  logic [mlp_pkg::DATA_BITS-1:0] bias,
   input  logic [mlp_pkg::DATA_BITS-1:0] weight,
   input  logic [mlp_pkg::DATA_BITS-1:0] act,
   output logic                          busy,
   output logic [mlp_pkg::OUT_BITS-1:0]  result
);
   import mlp_pkg::*;

   logic                        issue_d_ff;
   logic                        prod_v_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [ACC_BITS-1:0]  acc_ff;
   logic signed [ACC_BITS-1:0]  acc_in;
   logic signed [ACC_BITS-1:0]  shifted;

   // pipeline valids: read data, then product
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_d_ff <= 1'b0;
         prod_v_ff  <= 1'b0;
      end else begin
         issue_d_ff <= ctl.issue;
         prod_v_ff  <= issue_d_ff;
      end
   end

   assign prod_in = PROD_BITS'($signed(weight) * $signed(act));

   // accumulator: bias scaled to the product format, then add products
   always_comb begin
      acc_in = acc_ff;
      if (ctl.load_bias) begin
         acc_in = ACC_BITS'($signed(bias)) <<< FRAC_BITS;
      end else if (prod_v_ff) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (issue_d_ff) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign busy = issue_d_ff | prod_v_ff;

   // round toward zero (sum is non-negative here), saturate, clip at zero
   always_comb begin
      shifted = acc_ff >>> FRAC_BITS;
      if (acc_ff[ACC_BITS-1]) begin
         result = '0;
      end else if (|shifted[ACC_BITS-1:OUT_BITS]) begin
         result = '1;
      end else begin
         result = shifted[OUT_BITS-1:0];
      end
   end

endmodule

/* src/mlp_relu_inference.sv */
// ----------------------------------------------------------------------------
// mlp_relu_inference
// Fully connected ReLU network, forward pass, signed fixed point.
// ----------------------------------------------------------------------------
// Load items (weight, bias, input element) are taken back to back while
// the block is idle. An input element with req_tlast set starts an
// inference: every layer in use runs on one shared multiplier fed by one
// read port of the weight RAM, so each output neuron needs one bias fetch,
// one product per input and a drain of the multiply pipeline. The run
// stalls while a result of the last layer waits for rsp_tready. req_tready
// is low during a run. Results come out in neuron order, the last one with
// rsp_tlast. Weight, bias and activation RAMs are not cleared by reset; an
// entry must be written before an inference reads it. Activations alternate
// between two halves of the activation RAM, inputs in the first half.
// ----------------------------------------------------------------------------
module mlp_relu_inference #(
   parameter int FRAC_BITS = mlp_pkg::FRAC_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // layer_sel[1:0], row_index[5:2], col_index[9:6], value[25:10], zeros
   input  logic [mlp_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // op[1:0]
   input  logic [mlp_pkg::OP_BITS-1:0]       req_tuser,
   input  logic                              req_tlast,
   // result items
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_index[3:0], out_value[18:4], zeros
   output logic [mlp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                              rsp_tlast,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mlp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [mlp_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [mlp_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import mlp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_BIAS  = 4'b0010,
      ST_RUN   = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   // clamp a width register to the last neuron index
   function automatic logic [IDX_BITS-1:0] last_index(input logic [CNT_BITS-1:0] w);
      logic [CNT_BITS-1:0] wm1;
      wm1 = w - 1'b1;
      if (w == '0) begin
         return '0;
      end else if (w > CNT_BITS'(MAX_WIDTH)) begin
         return IDX_BITS'(MAX_WIDTH - 1);
      end else begin
         return wm1[IDX_BITS-1:0];
      end
   endfunction

   // clamp the layer count to the last layer index
   function automatic logic [LAYER_BITS-1:0] last_layer(input logic [LCNT_BITS-1:0] n);
      logic [LCNT_BITS-1:0] nm1;
      nm1 = n - 1'b1;
      if (n == '0) begin
         return '0;
      end else if (n > LCNT_BITS'(MAX_LAYERS)) begin
         return LAYER_BITS'(MAX_LAYERS - 1);
      end else begin
         return nm1[LAYER_BITS-1:0];
      end
   endfunction

   // request fields
   logic [LAYER_BITS-1:0] req_layer;
   logic [IDX_BITS-1:0]   req_row;
   logic [IDX_BITS-1:0]   req_col;
   logic [DATA_BITS-1:0]  req_value;
   op_type                req_op;
   logic                  accept;

   assign {req_value, req_col, req_row, req_layer} =
      req_tdata[DATA_BITS+2*IDX_BITS+LAYER_BITS-1:0];
   assign req_op = op_type'(req_tuser);

   // configuration registers
   logic [LCNT_BITS-1:0] lcount_ff;
   logic [CNT_BITS-1:0]  inw_ff;
   logic [CNT_BITS-1:0]  wid1_ff;
   logic [CNT_BITS-1:0]  wid2_ff;
   logic [CNT_BITS-1:0]  wid3_ff;
   logic [CNT_BITS-1:0]  wid4_ff;
   logic                 csr_wr;
   reg_type              csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = reg_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         lcount_ff <= LCNT_BITS'(1);
         inw_ff    <= CNT_BITS'(MAX_WIDTH);
         wid1_ff   <= CNT_BITS'(MAX_WIDTH);
         wid2_ff   <= CNT_BITS'(MAX_WIDTH);
         wid3_ff   <= CNT_BITS'(MAX_WIDTH);
         wid4_ff   <= CNT_BITS'(MAX_WIDTH);
      end else if (csr_wr) begin
         case (csr_idx)
            REG_LAYER_COUNT: lcount_ff <= csr_pwdata[LCNT_BITS-1:0];
            REG_INPUT_WIDTH: inw_ff    <= csr_pwdata[CNT_BITS-1:0];
            REG_WIDTH_ONE:   wid1_ff   <= csr_pwdata[CNT_BITS-1:0];
            REG_WIDTH_TWO:   wid2_ff   <= csr_pwdata[CNT_BITS-1:0];
            REG_WIDTH_THREE: wid3_ff   <= csr_pwdata[CNT_BITS-1:0];
            REG_WIDTH_FOUR:  wid4_ff   <= csr_pwdata[CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // register read
   always_comb begin
      case (csr_idx)
         REG_LAYER_COUNT: csr_prdata = CSR_DATA_BITS'(lcount_ff);
         REG_INPUT_WIDTH: csr_prdata = CSR_DATA_BITS'(inw_ff);
         REG_WIDTH_ONE:   csr_prdata = CSR_DATA_BITS'(wid1_ff);
         REG_WIDTH_TWO:   csr_prdata = CSR_DATA_BITS'(wid2_ff);
         REG_WIDTH_THREE: csr_prdata = CSR_DATA_BITS'(wid3_ff);
         REG_WIDTH_FOUR:  csr_prdata = CSR_DATA_BITS'(wid4_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // sequencer state
   state_type             state_ff, state_in;
   logic [LAYER_BITS-1:0] layer_ff, layer_in;
   logic [LAYER_BITS-1:0] nlast_ff, nlast_in;
   logic [IDX_BITS-1:0]   row_ff, row_in;
   logic [IDX_BITS-1:0]   col_ff, col_in;
   logic [IDX_BITS-1:0]   nin_ff, nin_in;
   logic [IDX_BITS-1:0]   nout_ff, nout_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0]   rsp_index_ff, rsp_index_in;
   logic [OUT_BITS-1:0]   rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;

   // datapath
   mac_ctl_type           mac_ctl;
   logic                  mac_busy;
   logic [OUT_BITS-1:0]   mac_result;
   logic [DATA_BITS-1:0]  w_rdata;
   logic [DATA_BITS-1:0]  b_rdata;
   logic [DATA_BITS-1:0]  a_rdata;
   logic                  act_wr_en;
   logic [IDX_BITS:0]     act_wr_addr;
   logic [DATA_BITS-1:0]  act_wr_data;

   logic [IDX_BITS-1:0]   in_last;
   logic [CNT_BITS-1:0]   next_wid;
   logic                  is_last_layer;
   logic                  out_free;
   logic                  commit;
   logic                  start;

   assign req_tready    = (state_ff == ST_IDLE);
   assign accept        = req_tvalid & req_tready;
   assign in_last       = last_index(inw_ff);
   assign is_last_layer = (layer_ff == nlast_ff);
   assign out_free      = ~rsp_valid_ff | rsp_tready;
   assign start         = accept & (req_op == OP_INPUT) & req_tlast;
   // neuron sum final and, on the last layer, room for the result
   assign commit        = (state_ff == ST_DRAIN) & ~mac_busy & (~is_last_layer | out_free);

   // width of the layer after the current one
   always_comb begin
      case (layer_ff)
         LAYER_BITS'(0): next_wid = wid2_ff;
         LAYER_BITS'(1): next_wid = wid3_ff;
         default:        next_wid = wid4_ff;
      endcase
   end

   assign mac_ctl.issue     = (state_ff == ST_RUN);
   assign mac_ctl.load_bias = (state_ff == ST_RUN) & (col_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      layer_in = layer_ff;
      nlast_in = nlast_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      nin_in   = nin_ff;
      nout_in  = nout_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               layer_in = '0;
               row_in   = '0;
               nin_in   = in_last;
               nout_in  = last_index(wid1_ff);
               nlast_in = last_layer(lcount_ff);
               state_in = ST_BIAS;
            end
         end
         ST_BIAS: begin
            col_in   = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (col_ff == nin_ff) begin
               state_in = ST_DRAIN;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (commit) begin
               if (row_ff != nout_ff) begin
                  row_in   = row_ff + 1'b1;
                  state_in = ST_BIAS;
               end else if (is_last_layer) begin
                  state_in = ST_IDLE;
               end else begin
                  layer_in = layer_ff + 1'b1;
                  row_in   = '0;
                  nin_in   = nout_ff;
                  nout_in  = last_index(next_wid);
                  state_in = ST_BIAS;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         layer_ff <= '0;
         nlast_ff <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         nin_ff   <= '0;
         nout_ff  <= '0;
      end else begin
         state_ff <= state_in;
         layer_ff <= layer_in;
         nlast_ff <= nlast_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         nin_ff   <= nin_in;
         nout_ff  <= nout_in;
      end
   end

   // result register: load on the last layer, free when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (commit && is_last_layer) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = row_ff;
         rsp_value_in = mac_result;
         rsp_last_in  = (row_ff == nout_ff);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - OUT_BITS - IDX_BITS){1'b0}},
                        rsp_value_ff, rsp_index_ff};

   // activation write: neuron results during a run, input elements when idle
   always_comb begin
      if (commit) begin
         act_wr_en   = 1'b1;
         act_wr_addr = {~layer_ff[0], row_ff};
         act_wr_data = {1'b0, mac_result};
      end else begin
         act_wr_en   = accept & (req_op == OP_INPUT) & (req_row <= in_last);
         act_wr_addr = {1'b0, req_row};
         act_wr_data = req_value;
      end
   end

   mlp_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (WEIGHT_DEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (accept & (req_op == OP_WEIGHT)),
      .wr_addr ({req_layer, req_row, req_col}),
      .wr_data (req_value),
      .rd_addr ({layer_ff, row_ff, col_ff}),
      .rd_data (w_rdata)
   );

   mlp_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (BIAS_DEPTH)
   ) u_bias_ram (
      .clock   (clock),
      .wr_en   (accept & (req_op == OP_BIAS)),
      .wr_addr ({req_layer, req_row}),
      .wr_data (req_value),
      .rd_addr ({layer_ff, row_ff}),
      .rd_data (b_rdata)
   );

   mlp_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (ACT_DEPTH)
   ) u_act_ram (
      .clock   (clock),
      .wr_en   (act_wr_en),
      .wr_addr (act_wr_addr),
      .wr_data (act_wr_data),
      .rd_addr ({layer_ff[0], col_ff}),
      .rd_data (a_rdata)
   );

   mlp_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .bias   (b_rdata),
      .weight (w_rdata),
      .act    (a_rdata),
      .busy   (mac_busy),
      .result (mac_result)
   );

endmodule

/* src/mlp_checker.sv */
// ----------------------------------------------------------------------------
// mlp_checker
// Port-level checks of the MLP inference block, bound to its top level.
// ----------------------------------------------------------------------------
`include "mlp_relu_inference_defines.svh"

module mlp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [mlp_pkg::OP_BITS-1:0]       req_tuser,
   input logic                              req_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [mlp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                              rsp_tlast
);
   import mlp_pkg::*;

   // a stalled result item holds
   `MLP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result item changed while stalled")

   // the final input element starts a run and drops ready
   `MLP_ASSERT_NEXT(a_run_starts, req_tvalid && req_tready && req_tuser == OP_INPUT && req_tlast, !req_tready, "no run after final input element")

   // any other item is a load after which ready stays high
   `MLP_ASSERT_NEXT(a_load_ready, req_tvalid && req_tready && !(req_tuser == OP_INPUT && req_tlast), req_tready, "load item did not return to ready")

   // results only come out of a run
   `MLP_ASSERT_SAME(a_rsp_from_run, $rose(rsp_tvalid), !$past(req_tready), "result item outside a run")

endmodule

bind mlp_relu_inference mlp_checker u_mlp_checker (.*);

/* tb/sv/mlp_relu_inference_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_relu_inference_tb
// Self-checking bench for the fixed-point ReLU network block.
// ----------------------------------------------------------------------------
// Loads weights, biases and input elements over the req_ stream and programs
// the layer shape over the csr_ port while the block is idle. A behavioral
// forward pass predicts every output neuron of each run; results on the rsp_
// stream are compared in order, field by field. Directed runs cover
// saturation, clipping, truncation, a four-layer chain that reuses the input
// buffer, and the items the block must ignore. Random runs follow, with
// random shapes, random values and random idling on both streams.
// ----------------------------------------------------------------------------
module mlp_relu_inference_tb;
   import mlp_pkg::*;

   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int          FRAC          = FRAC_DEFAULT;
   localparam logic [14:0] ACT_LIMIT     = 15'h7FFF;
   localparam int          RANDOM_ITEMS  = 260;
   localparam int          LOAD_BUDGET   = 40;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          TAIL_CYCLES   = 64;
   localparam int          PRINT_LIMIT   = 20;

   typedef enum {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_BEAT} sink_mode_type;

   // register values, indexed by reg_type
   typedef int shape_type [6];

   typedef struct {
      logic [1:0]  op;
      logic [1:0]  layer;
      logic [3:0]  row;
      logic [3:0]  col;
      logic [15:0] value;
      logic        last;
   } net_item_type;

   typedef struct {
      logic [3:0]  index;
      logic [14:0] value;
      logic        last;
   } neuron_out_type;

   // block ports
   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic [OP_BITS-1:0]       req_tuser   = '0;
   logic                     req_tlast   = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // predictor state
   logic signed [15:0] weight_mem [MAX_LAYERS][MAX_WIDTH][MAX_WIDTH];
   bit                 weight_set [MAX_LAYERS][MAX_WIDTH][MAX_WIDTH];
   logic signed [15:0] bias_mem [MAX_LAYERS][MAX_WIDTH];
   bit                 bias_set [MAX_LAYERS][MAX_WIDTH];
   logic signed [15:0] ping_act [MAX_WIDTH];
   logic signed [15:0] pong_act [MAX_WIDTH];
   bit                 ping_set [MAX_WIDTH];
   shape_type          csr_shadow = '{1, 16, 16, 16, 16, 16};
   neuron_out_type     pending_outputs [$];
   neuron_out_type     wanted;

   int            errors       = 0;
   int            random_items = 0;
   int            burst_left   = 0;
   int            sink_left    = 0;
   sink_mode_type sink_mode    = SINK_OPEN;

   mlp_relu_inference dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   // ------------------------------------------------------------------------
   // forward pass predictor
   // ------------------------------------------------------------------------
   function automatic int clamp_width(int raw);
      if (raw < 1) return 1;
      if (raw > MAX_WIDTH) return MAX_WIDTH;
      return raw;
   endfunction

   function automatic int clamp_layers(int raw);
      if (raw < 1) return 1;
      if (raw > MAX_LAYERS) return MAX_LAYERS;
      return raw;
   endfunction

   // truncate toward zero, saturate, clip at zero
   function automatic logic [14:0] relu_scale(longint acc);
      if (acc < 0) return '0;
      acc = acc >>> FRAC;
      if (acc > longint'(ACT_LIMIT)) return ACT_LIMIT;
      return acc[14:0];
   endfunction

   task automatic predict_forward_pass();
      logic signed [15:0] src [MAX_WIDTH];
      logic signed [15:0] dst [MAX_WIDTH];
      longint acc;
      int n_in;
      int n_out;
      src = ping_act;
      dst = pong_act;
      n_in = clamp_width(csr_shadow[REG_INPUT_WIDTH]);
      n_out = n_in;
      for (int l = 0; l < clamp_layers(csr_shadow[REG_LAYER_COUNT]); l++) begin
         n_out = clamp_width(csr_shadow[int'(REG_WIDTH_ONE) + l]);
         for (int r = 0; r < n_out; r++) begin
            acc = longint'(bias_mem[l][r]) <<< FRAC;
            for (int c = 0; c < n_in; c++)
               acc += longint'(weight_mem[l][r][c]) * longint'(src[c]);
            dst[r] = {1'b0, relu_scale(acc)};
            // even layers fill pong, odd layers overwrite ping
            if (l % 2 == 0) begin
               pong_act[r] = dst[r];
            end else begin
               ping_act[r] = dst[r];
               ping_set[r] = 1'b1;
            end
         end
         src = dst;
         n_in = n_out;
      end
      for (int r = 0; r < n_out; r++)
         pending_outputs.insert(pending_outputs.size(),
                                neuron_out_type'{r[3:0], src[r][14:0], r == n_out - 1});
   endtask

   task automatic absorb_item(input net_item_type it);
      case (it.op)
         OP_WEIGHT: begin
            weight_mem[it.layer][it.row][it.col] = it.value;
            weight_set[it.layer][it.row][it.col] = 1'b1;
         end
         OP_BIAS: begin
            bias_mem[it.layer][it.row] = it.value;
            bias_set[it.layer][it.row] = 1'b1;
         end
         OP_INPUT: begin
            if (int'(it.row) < clamp_width(csr_shadow[REG_INPUT_WIDTH])) begin
               ping_act[it.row] = it.value;
               ping_set[it.row] = 1'b1;
            end
            if (it.last)
               predict_forward_pass();
         end
         default: ;
      endcase
   endtask

   function automatic bit counts_as_work(net_item_type it);
      if (it.op == OP_WEIGHT || it.op == OP_BIAS) return 1'b1;
      if (it.op == OP_INPUT)
         return it.last || int'(it.row) < clamp_width(csr_shadow[REG_INPUT_WIDTH]);
      return 1'b0;
   endfunction

   // entries a shape would read that were never written
   function automatic int load_cost(shape_type s);
      int cost;
      int n_in;
      int n_out;
      cost = 0;
      n_in = clamp_width(s[REG_INPUT_WIDTH]);
      for (int c = 0; c < n_in; c++)
         if (!ping_set[c]) cost++;
      for (int l = 0; l < clamp_layers(s[REG_LAYER_COUNT]); l++) begin
         n_out = clamp_width(s[int'(REG_WIDTH_ONE) + l]);
         for (int r = 0; r < n_out; r++) begin
            if (!bias_set[l][r]) cost++;
            for (int c = 0; c < n_in; c++)
               if (!weight_set[l][r][c]) cost++;
         end
         n_in = n_out;
      end
      return cost;
   endfunction

   // ------------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outputs.size() == 0) begin
            report_mismatch($sformatf("result index %0d value %0d with none expected",
                                      rsp_tdata[3:0], rsp_tdata[18:4]));
         end else begin
            wanted = pending_outputs.pop_front();
            if (rsp_tdata[3:0] !== wanted.index)
               report_mismatch($sformatf("out_index %0d, expected %0d",
                                         rsp_tdata[3:0], wanted.index));
            if (rsp_tdata[18:4] !== wanted.value)
               report_mismatch($sformatf("out_value %0d at index %0d, expected %0d",
                                         rsp_tdata[18:4], wanted.index, wanted.value));
            if (rsp_tlast !== wanted.last)
               report_mismatch($sformatf("out_last %b at index %0d, expected %b",
                                         rsp_tlast, wanted.index, wanted.last));
         end
      end
   end

   // result sink: stall pattern chosen at random, held for a random stretch
   always @(negedge clock) begin
      if (sink_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 3));
         sink_left = $urandom_range(8, 80);
      end
      sink_left--;
      case (sink_mode)
         SINK_OPEN: rsp_tready <= 1'b1;
         SINK_COIN: rsp_tready <= 1'($urandom_range(0, 1));
         SINK_SLOW: rsp_tready <= ($urandom_range(0, 4) == 0);
         default:   rsp_tready <= (sink_left % 3 == 0);
      endcase
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic net_item_type make_item(logic [1:0] op, int layer, int row, int col,
                                              logic [15:0] value, bit last);
      net_item_type it;
      it.op    = op;
      it.layer = 2'(layer);
      it.row   = 4'(row);
      it.col   = 4'(col);
      it.value = value;
      it.last  = last;
      return it;
   endfunction

   // mostly within +-2.0, now and then the full range
   function automatic logic [15:0] rand_value();
      int v;
      if ($urandom_range(0, 7) == 0) return 16'($urandom);
      v = int'($urandom_range(0, 1024)) - 512;
      return v[15:0];
   endfunction

   task automatic send_item(input net_item_type it);
      @(negedge clock);
      // gap between bursts
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 10);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tlast  <= it.last;
      req_tdata  <= {6'b0, it.value, it.col, it.row, it.layer};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      absorb_item(it);
   endtask

   // stop sending, wait out every predicted result, then let the block settle
   task automatic wait_until_drained(input int settle);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic verify_reg(input reg_type idx);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== 32'(csr_shadow[idx]))
         report_mismatch($sformatf("register %s reads %0d, expected %0d",
                                   idx.name(), csr_prdata, csr_shadow[idx]));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_reg(input reg_type idx, input int val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= 32'(val);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_shadow[idx] = val;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      verify_reg(idx);
   endtask

   task automatic write_shape(input shape_type s);
      write_reg(REG_LAYER_COUNT, s[REG_LAYER_COUNT]);
      write_reg(REG_INPUT_WIDTH, s[REG_INPUT_WIDTH]);
      write_reg(REG_WIDTH_ONE, s[REG_WIDTH_ONE]);
      write_reg(REG_WIDTH_TWO, s[REG_WIDTH_TWO]);
      write_reg(REG_WIDTH_THREE, s[REG_WIDTH_THREE]);
      write_reg(REG_WIDTH_FOUR, s[REG_WIDTH_FOUR]);
   endtask

   function automatic int pick_width();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 12) return $urandom_range(1, 4);
      if (roll < 15) return $urandom_range(5, 16);
      if (roll < 17) return 0;
      return $urandom_range(17, 31);
   endfunction

   function automatic shape_type pick_shape();
      shape_type s;
      s[REG_LAYER_COUNT] = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4)
                                                      : $urandom_range(0, 7);
      s[REG_INPUT_WIDTH] = pick_width();
      s[REG_WIDTH_ONE]   = pick_width();
      s[REG_WIDTH_TWO]   = pick_width();
      s[REG_WIDTH_THREE] = pick_width();
      s[REG_WIDTH_FOUR]  = pick_width();
      return s;
   endfunction

   // items the block ignores, inputs outside the shape in use, or random weight and bias loads
   function automatic net_item_type noise_item(int n_in);
      int kind;
      kind = $urandom_range(0, 2);
      if (kind == 0)
         return make_item(OP_UNUSED, $urandom_range(0, 3), $urandom_range(0, 15),
                          $urandom_range(0, 15), 16'($urandom), $urandom_range(0, 1));
      if (kind == 1 && n_in < MAX_WIDTH)
         return make_item(OP_INPUT, $urandom_range(0, 3), $urandom_range(n_in, 15),
                          $urandom_range(0, 15), rand_value(), 1'b0);
      return make_item($urandom_range(0, 1) ? OP_WEIGHT : OP_BIAS, $urandom_range(0, 3),
                       $urandom_range(0, 15), $urandom_range(0, 15), rand_value(),
                       $urandom_range(0, 1));
   endfunction

   // one shape: program it, load what it reads, then start the run unless the final element is left out
   task automatic run_network_phase(input shape_type s);
      net_item_type batch [$];
      net_item_type swap;
      int n_in;
      int n_out;
      int j;
      int fin_row;
      wait_until_drained(SETTLE_CYCLES);
      write_shape(s);
      n_in = clamp_width(s[REG_INPUT_WIDTH]);
      for (int r = 0; r < n_in; r++)
         if (!ping_set[r] || $urandom_range(0, 1))
            batch.insert(batch.size(), make_item(OP_INPUT, $urandom_range(0, 3), r,
                                                 $urandom_range(0, 15), rand_value(),
                                                 1'b0));
      for (int l = 0; l < clamp_layers(s[REG_LAYER_COUNT]); l++) begin
         n_out = clamp_width(s[int'(REG_WIDTH_ONE) + l]);
         for (int r = 0; r < n_out; r++) begin
            if (!bias_set[l][r] || $urandom_range(0, 5) == 0)
               batch.insert(batch.size(), make_item(OP_BIAS, l, r, $urandom_range(0, 15),
                                                    rand_value(), $urandom_range(0, 1)));
            for (int c = 0; c < n_in; c++)
               if (!weight_set[l][r][c] || $urandom_range(0, 5) == 0)
                  batch.insert(batch.size(), make_item(OP_WEIGHT, l, r, c, rand_value(),
                                                       $urandom_range(0, 1)));
         end
         n_in = n_out;
      end
      n_in = clamp_width(s[REG_INPUT_WIDTH]);
      repeat ($urandom_range(0, 3)) batch.insert(batch.size(), noise_item(n_in));
      for (int i = batch.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = batch[i];
         batch[i] = batch[j];
         batch[j] = swap;
      end
      // final element, left out now and then; sometimes outside input_width
      if ($urandom_range(0, 7) != 0) begin
         if (n_in < MAX_WIDTH && $urandom_range(0, 3) == 0)
            fin_row = $urandom_range(n_in, 15);
         else
            fin_row = $urandom_range(0, n_in - 1);
         batch.insert(batch.size(), make_item(OP_INPUT, $urandom_range(0, 3), fin_row,
                                              $urandom_range(0, 15), rand_value(), 1'b1));
      end
      foreach (batch[i]) begin
         send_item(batch[i]);
         if (counts_as_work(batch[i])) random_items++;
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_register_defaults();
      verify_reg(REG_LAYER_COUNT);
      verify_reg(REG_INPUT_WIDTH);
      verify_reg(REG_WIDTH_ONE);
      verify_reg(REG_WIDTH_TWO);
      verify_reg(REG_WIDTH_THREE);
      verify_reg(REG_WIDTH_FOUR);
   endtask

   // one layer, two inputs, three neurons: saturate, clip, truncate
   task automatic test_saturation_and_clip();
      wait_until_drained(SETTLE_CYCLES);
      write_reg(REG_LAYER_COUNT, 1);
      write_reg(REG_INPUT_WIDTH, 2);
      write_reg(REG_WIDTH_ONE, 3);
      send_item(make_item(OP_WEIGHT, 0, 0, 0, 16'h7FFF, 1'b0));
      send_item(make_item(OP_WEIGHT, 0, 0, 1, 16'h7FFF, 1'b0));
      send_item(make_item(OP_WEIGHT, 0, 1, 0, 16'h8000, 1'b0));
      send_item(make_item(OP_WEIGHT, 0, 1, 1, 16'h0000, 1'b0));
      send_item(make_item(OP_WEIGHT, 0, 2, 0, 16'h0080, 1'b0));
      send_item(make_item(OP_WEIGHT, 0, 2, 1, 16'h0001, 1'b0));
      send_item(make_item(OP_BIAS, 0, 0, 0, 16'h7FFF, 1'b0));
      send_item(make_item(OP_BIAS, 0, 1, 0, 16'h0000, 1'b0));
      send_item(make_item(OP_BIAS, 0, 2, 0, 16'hFFFF, 1'b0));
      send_item(make_item(OP_INPUT, 0, 0, 0, 16'h7FFF, 1'b0));
      send_item(make_item(OP_INPUT, 0, 1, 0, 16'h0100, 1'b1));
   endtask

   // layer_count above the maximum, a zero width, every layer one neuron
   task automatic test_deep_chain_reuse();
      wait_until_drained(SETTLE_CYCLES);
      write_shape('{7, 1, 1, 1, 1, 0});
      for (int l = 0; l < MAX_LAYERS; l++) begin
         send_item(make_item(OP_WEIGHT, l, 0, 0, 16'h0200, 1'b0));
         send_item(make_item(OP_BIAS, l, 0, 0, 16'h0040, 1'b0));
      end
      send_item(make_item(OP_INPUT, 0, 0, 0, 16'h0100, 1'b1));
   endtask

   // unused code, final mark on loads, final element outside input_width;
   // the run then reads the input slot the previous run overwrote
   task automatic test_ignored_items();
      send_item(make_item(OP_UNUSED, 3, 15, 15, 16'hFFFF, 1'b1));
      send_item(make_item(OP_WEIGHT, 3, 0, 0, 16'h0180, 1'b1));
      send_item(make_item(OP_BIAS, 2, 15, 15, 16'h8000, 1'b1));
      send_item(make_item(OP_INPUT, 3, 15, 15, 16'h7FFF, 1'b1));
   endtask

   task automatic test_random_networks();
      shape_type s;
      int tries;
      // widest input and last layer, deepest chain
      run_network_phase('{4, 31, 1, 1, 1, 16});
      while (random_items < RANDOM_ITEMS) begin
         tries = 0;
         do begin
            s = pick_shape();
            tries++;
         end while (load_cost(s) > LOAD_BUDGET && tries < 100);
         if (load_cost(s) > LOAD_BUDGET) s = '{1, 1, 1, 1, 1, 1};
         run_network_phase(s);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_register_defaults();
      test_saturation_and_clip();
      test_deep_chain_reuse();
      test_ignored_items();
      test_random_networks();
      wait_until_drained(TAIL_CYCLES);
      if (errors == 0)
         $display("mlp_relu_inference: match");
      else
         $display("mlp_relu_inference: mismatch");
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("mlp_relu_inference: mismatch");
      $finish;
   end

endmodule
